>>> hw/rtl/csq_pkg.sv
// shared constants for the coil stage sequencer
package csq_pkg;

	// configuration register indexes and widths
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 10;
	localparam int BIAS_BITS = 10;
	localparam int QUAL_BITS = 4;
	localparam int RUN_BITS = 4;

	localparam logic [CFG_IDX_BITS-1:0] REG_DROP_BIAS = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUALIFY_COUNT = 1'd1;

	localparam logic [BIAS_BITS-1:0] DROP_BIAS_RESET = 10'd4;
	localparam logic [QUAL_BITS-1:0] QUALIFY_COUNT_RESET = 4'd3;

	// result field widths and the number of sensor ports
	localparam int COIL_OUT_BITS = 4;
	localparam int PHASE_OUT_BITS = 3;
	localparam int SENSOR_PORTS = 4;

endpackage

>>> hw/rtl/coil_stage_sequencer.sv
// top level of the coil stage sequencer
//
// usage:
//   input channel (in_valid / in_stall) carries one tick: switch_on and the four
//   gate sensor samples sense_a..sense_d. output channel (out_valid / out_stall)
//   returns one result per tick: coil_enable, ready_led and phase_now, showing
//   the state after that tick.
//   a tick is captured in the input register on its transfer; while held
//   there it is evaluated against the phase, run count and baselines and the
//   result lands in the output register once that register is free. one tick
//   is taken per cycle while the receiver does not stall; the rate is set by
//   the single compare and counter update between the two registers.
//   in_stall rises only while both the input register and the output register
//   hold data and the receiver stalls; then everything holds in place.
//   configuration (cfg_we, cfg_index, cfg_data) writes drop_bias or
//   qualify_count at once; write only while no tick is in flight.
//   reset (arst_n low) returns to idle, clears the run count, empties both
//   registers and restores drop_bias = 4, qualify_count = 3. baselines are
//   not cleared: they are always latched before any coil phase reads them.
module coil_stage_sequencer
	import csq_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int COIL_COUNT = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// tick input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      switch_on,
	input  logic [SAMPLE_BITS-1:0]    sense_a,
	input  logic [SAMPLE_BITS-1:0]    sense_b,
	input  logic [SAMPLE_BITS-1:0]    sense_c,
	input  logic [SAMPLE_BITS-1:0]    sense_d,
	// result output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COIL_OUT_BITS-1:0]  coil_enable,
	output logic                      ready_led,
	output logic [PHASE_OUT_BITS-1:0] phase_now
);

	// phase: 0 idle, 1..COIL_COUNT coil active, COIL_COUNT+1 release wait
	localparam int PH_W = $clog2(COIL_COUNT + 2);

	// configuration registers
	logic [BIAS_BITS-1:0] drop_bias_q;
	logic [QUAL_BITS-1:0] qualify_count_q;

	// input register
	logic                 valid_s1;
	logic                 switch_s1;
	logic [SENSOR_PORTS-1:0][SAMPLE_BITS-1:0] sense_s1;

	// sequencer state
	logic [PH_W-1:0]      phase_q;
	logic [RUN_BITS-1:0]  low_run_q;
	logic [COIL_COUNT-1:0][SAMPLE_BITS-1:0] baseline_q;

	logic [COIL_COUNT-1:0][SAMPLE_BITS-1:0] samples;
	logic [PH_W-1:0]      phase_nxt;
	logic [RUN_BITS-1:0]  low_run_nxt;
	logic                 latch_en;
	logic                 advance;
	logic                 in_take;
	logic [COIL_OUT_BITS-1:0] coils_nxt;
	logic [PH_W+PHASE_OUT_BITS-1:0] phase_ext;

	// handshake: the output register frees when empty or taken this cycle
	assign advance = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_bias_q <= DROP_BIAS_RESET;
			qualify_count_q <= QUALIFY_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DROP_BIAS:     drop_bias_q <= cfg_data[BIAS_BITS-1:0];
				REG_QUALIFY_COUNT: qualify_count_q <= cfg_data[QUAL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			switch_s1 <= switch_on;
			sense_s1 <= {sense_d, sense_c, sense_b, sense_a};
		end
	end

	// sensors past the fourth read as zero
	always_comb begin
		for (int k = 0; k < COIL_COUNT; k++) begin
			if (k < SENSOR_PORTS) begin
				samples[k] = sense_s1[k];
			end else begin
				samples[k] = '0;
			end
		end
	end

	csq_step #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COIL_COUNT  (COIL_COUNT),
		.PH_W        (PH_W)
	) u_step (
		.phase         (phase_q),
		.low_run       (low_run_q),
		.switch_on     (switch_s1),
		.samples       (samples),
		.baselines     (baseline_q),
		.drop_bias     (drop_bias_q),
		.qualify_count (qualify_count_q),
		.phase_nxt     (phase_nxt),
		.low_run_nxt   (low_run_nxt),
		.latch_en      (latch_en)
	);

	// phase and run count move only when a tick is evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			low_run_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			low_run_q <= low_run_nxt;
		end
	end

	// baselines latched on the press that leaves idle
	always_ff @(posedge clk) begin
		if (advance && latch_en) begin
			baseline_q <= samples;
		end
	end

	// one-hot coil drive from the new phase, low four bits only
	always_comb begin
		for (int j = 0; j < COIL_OUT_BITS; j++) begin
			coils_nxt[j] = (j < COIL_COUNT) && (phase_nxt == PH_W'(j + 1));
		end
	end

	assign phase_ext = {{PHASE_OUT_BITS{1'b0}}, phase_nxt};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coil_enable <= coils_nxt;
			ready_led <= (phase_nxt == '0);
			phase_now <= phase_ext[PHASE_OUT_BITS-1:0];
		end
	end

endmodule

>>> hw/rtl/csq_step.sv
// next-state logic: baseline latch, pass test, run count and phase advance
module csq_step
	import csq_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int COIL_COUNT = 4,
	parameter int PH_W = 3
) (
	input  logic [PH_W-1:0]                           phase,
	input  logic [RUN_BITS-1:0]                       low_run,
	input  logic                                      switch_on,
	input  logic [COIL_COUNT-1:0][SAMPLE_BITS-1:0]    samples,
	input  logic [COIL_COUNT-1:0][SAMPLE_BITS-1:0]    baselines,
	input  logic [BIAS_BITS-1:0]                      drop_bias,
	input  logic [QUAL_BITS-1:0]                      qualify_count,
	output logic [PH_W-1:0]                           phase_nxt,
	output logic [RUN_BITS-1:0]                       low_run_nxt,
	output logic                                      latch_en
);

	localparam int CMP_W = ((SAMPLE_BITS > BIAS_BITS) ? SAMPLE_BITS : BIAS_BITS) + 1;
	localparam logic [PH_W-1:0] PH_IDLE = '0;

	logic [SAMPLE_BITS-1:0] sel_sample;
	logic [SAMPLE_BITS-1:0] sel_base;
	logic                   in_coil;
	logic                   pass;
	logic [CMP_W-1:0]       sum;
	logic [RUN_BITS:0]      run;
	logic [QUAL_BITS-1:0]   need;

	// pick the sensor and baseline of the active coil
	always_comb begin
		sel_sample = '0;
		sel_base = '0;
		for (int k = 0; k < COIL_COUNT; k++) begin
			if (phase == PH_W'(k + 1)) begin
				sel_sample = sel_sample | samples[k];
				sel_base = sel_base | baselines[k];
			end
		end
	end

	assign in_coil = (phase != PH_IDLE) && (phase <= PH_W'(COIL_COUNT));
	assign sum = CMP_W'(sel_sample) + CMP_W'(drop_bias);
	assign pass = sum <= CMP_W'(sel_base);
	assign run = {1'b0, low_run} + (RUN_BITS+1)'(1);
	assign need = (qualify_count == '0) ? QUAL_BITS'(1) : qualify_count;

	always_comb begin
		phase_nxt = phase;
		low_run_nxt = low_run;
		latch_en = 1'b0;
		if (phase == PH_IDLE) begin
			if (switch_on) begin
				latch_en = 1'b1;
				phase_nxt = PH_W'(1);
				low_run_nxt = '0;
			end
		end else if (in_coil) begin
			if (pass) begin
				if (run >= (RUN_BITS+1)'(need)) begin
					phase_nxt = phase + PH_W'(1);
					low_run_nxt = '0;
				end else begin
					// saturate the run count
					low_run_nxt = run[RUN_BITS] ? '1 : run[RUN_BITS-1:0];
				end
			end else begin
				low_run_nxt = '0;
			end
		end else begin
			// release wait
			if (!switch_on) begin
				phase_nxt = PH_IDLE;
				low_run_nxt = '0;
			end
		end
	end

endmodule

>>> hw/rtl/csq_checker.sv
// port-level checks for the coil stage sequencer, bound to the top level
module csq_checker
	import csq_pkg::*;
#(
	parameter int COIL_COUNT = 4
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [COIL_OUT_BITS-1:0]  coil_enable,
	input logic                      ready_led,
	input logic [PHASE_OUT_BITS-1:0] phase_now
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coil_enable) && $stable(phase_now))
		else $error("stalled result changed");

	// input only backs up behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// at most one coil energized
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(coil_enable))
		else $error("more than one coil enabled");

	// ready led tracks the idle phase
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ready_led == (phase_now == '0))
		else $error("ready led disagrees with phase");

	// coil drive matches the reported phase
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (COIL_COUNT <= 4) && (phase_now != '0)
			&& (phase_now <= PHASE_OUT_BITS'(COIL_COUNT))
		|-> coil_enable == (COIL_OUT_BITS'(1) << (phase_now - PHASE_OUT_BITS'(1))))
		else $error("coil drive does not match phase");

endmodule

bind coil_stage_sequencer csq_checker #(.COIL_COUNT(COIL_COUNT)) u_csq_checker (.*);
